// ===== rtl/core/gyro_orientation_remap_blend_assert.svh =====
// Assertion macros for the gyro orientation remap and blend block.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef GYRO_ORIENTATION_REMAP_BLEND_ASSERT_SVH
`define GYRO_ORIENTATION_REMAP_BLEND_ASSERT_SVH

// The consequent must hold in the cycle after the trigger.
`define GORB_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

// The condition must hold at every clock edge outside reset.
`define GORB_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

// ===== rtl/core/gorb_pkg.sv =====
// Shared constants, types and the orientation table for the gyro remap block.
// No dependencies.
package gorb_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int PCT_W      = 7;
  localparam int ORIENT_W   = 5;
  localparam int MODE_W     = 2;
  localparam int ZEROS_W    = 3 * SAMPLE_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = ZEROS_W;

  localparam int ORIENT_COUNT = 24;
  localparam int DOWN_SHIFT   = 4;
  localparam logic [PCT_W-1:0] FULL_PERCENT = 7'd100;

  // Magnitude of a 16-bit value times a percentage, and its quotient by 100.
  localparam int PROD_W      = 22;
  localparam int RECIP_SHIFT = 29;
  localparam int RECIP_W     = 23;
  localparam logic [RECIP_W-1:0] RECIP_MULT = 23'd5368710;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ORIENT_ONE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIENT_TWO = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_MODE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ZEROS_ONE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ZEROS_TWO  = 3'd4;

  // Reference modes.
  localparam logic [MODE_W-1:0] REF_SINGLE = 2'd0;
  localparam logic [MODE_W-1:0] REF_MODEL  = 2'd1;
  localparam logic [MODE_W-1:0] REF_EARTH  = 2'd2;

  // Sensor axis codes.
  localparam logic [1:0] AX_R = 2'd0;
  localparam logic [1:0] AX_P = 2'd1;
  localparam logic [1:0] AX_Y = 2'd2;

  typedef logic [2:0][SAMPLE_W-1:0] axis3_t;

  typedef struct packed {
    logic [2:0][1:0] src;
    logic [2:0]      neg;
  } orient_map_t;

  function automatic orient_map_t mk(input logic [1:0] r, input logic [1:0] p,
                                     input logic [1:0] y, input logic [2:0] n);
    orient_map_t m;
    m.src[0] = r;
    m.src[1] = p;
    m.src[2] = y;
    m.neg    = n;
    return m;
  endfunction

  // neg bits are {yaw, pitch, roll}.
  function automatic orient_map_t orient_lookup(input logic [ORIENT_W-1:0] o);
    orient_map_t m;
    case (o)
      5'd1:    m = mk(AX_P, AX_R, AX_Y, 3'b001);
      5'd2:    m = mk(AX_R, AX_P, AX_Y, 3'b011);
      5'd3:    m = mk(AX_P, AX_R, AX_Y, 3'b010);
      5'd4:    m = mk(AX_Y, AX_P, AX_R, 3'b001);
      5'd5:    m = mk(AX_Y, AX_R, AX_P, 3'b101);
      5'd6:    m = mk(AX_Y, AX_P, AX_R, 3'b111);
      5'd7:    m = mk(AX_Y, AX_R, AX_P, 3'b011);
      5'd8:    m = mk(AX_R, AX_P, AX_Y, 3'b110);
      5'd9:    m = mk(AX_P, AX_R, AX_Y, 3'b111);
      5'd10:   m = mk(AX_R, AX_P, AX_Y, 3'b101);
      5'd11:   m = mk(AX_P, AX_R, AX_Y, 3'b100);
      5'd12:   m = mk(AX_Y, AX_P, AX_R, 3'b010);
      5'd13:   m = mk(AX_Y, AX_R, AX_P, 3'b110);
      5'd14:   m = mk(AX_Y, AX_P, AX_R, 3'b100);
      5'd15:   m = mk(AX_Y, AX_R, AX_P, 3'b000);
      5'd16:   m = mk(AX_P, AX_Y, AX_R, 3'b011);
      5'd17:   m = mk(AX_R, AX_Y, AX_P, 3'b111);
      5'd18:   m = mk(AX_P, AX_Y, AX_R, 3'b110);
      5'd19:   m = mk(AX_R, AX_Y, AX_P, 3'b010);
      5'd20:   m = mk(AX_P, AX_Y, AX_R, 3'b000);
      5'd21:   m = mk(AX_R, AX_Y, AX_P, 3'b100);
      5'd22:   m = mk(AX_P, AX_Y, AX_R, 3'b101);
      5'd23:   m = mk(AX_R, AX_Y, AX_P, 3'b001);
      default: m = mk(AX_R, AX_P, AX_Y, 3'b000);
    endcase
    // Indexes outside the table fall back to the first orientation.
    if (o >= ORIENT_W'(ORIENT_COUNT)) begin
      m = mk(AX_R, AX_P, AX_Y, 3'b000);
    end
    return m;
  endfunction

endpackage

// ===== rtl/core/gyro_orientation_remap_blend.sv =====
// Top level of the gyro orientation remap and blend block.
// Depends on gorb_pkg and gyro_orientation_remap_blend_assert.svh.
`include "gyro_orientation_remap_blend_assert.svh"

// The block takes one gyro item per clock cycle and returns its result exactly
// four cycles after the edge at which start was taken: out_strobe is high for
// that one cycle and the six rate outputs hold the result only then, so the
// receiver must take every result as it comes. The latency comes from the input
// register, the percentage multiply stage, the divide-by-100 reciprocal multiply
// stage and the result register. busy is high only during reset and the first
// cycle after it. Configuration writes must be made while no item is in flight.
module gyro_orientation_remap_blend #(
  parameter int ORIENT_COUNT = gorb_pkg::ORIENT_COUNT,
  parameter int DOWN_SHIFT   = gorb_pkg::DOWN_SHIFT
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [gorb_pkg::SAMPLE_W-1:0] in_sensor_x,
  input  logic signed [gorb_pkg::SAMPLE_W-1:0] in_sensor_y,
  input  logic signed [gorb_pkg::SAMPLE_W-1:0] in_sensor_z,
  input  logic        [gorb_pkg::PCT_W-1:0]    in_blend_percent,
  output logic                                 out_strobe,
  output logic signed [gorb_pkg::SAMPLE_W-1:0] out_main_roll,
  output logic signed [gorb_pkg::SAMPLE_W-1:0] out_main_pitch,
  output logic signed [gorb_pkg::SAMPLE_W-1:0] out_main_yaw,
  output logic signed [gorb_pkg::SAMPLE_W-1:0] out_alt_roll,
  output logic signed [gorb_pkg::SAMPLE_W-1:0] out_alt_pitch,
  output logic signed [gorb_pkg::SAMPLE_W-1:0] out_alt_yaw,
  input  logic                                 cfg_we,
  input  logic        [gorb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [gorb_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import gorb_pkg::*;

  // Configuration registers.
  logic [ORIENT_W-1:0] orient_one_r;
  logic [ORIENT_W-1:0] orient_two_r;
  logic [MODE_W-1:0]   ref_mode_r;
  logic [ZEROS_W-1:0]  zeros_one_r;
  logic [ZEROS_W-1:0]  zeros_two_r;

  logic busy_r;
  logic accept;

  // Input stage.
  logic                 s0_vld_r;
  axis3_t               s0_raw_r;
  logic [PCT_W-1:0]     s0_pct_r;
  logic [PCT_W-1:0]     pct_sat;

  // Remap and percentage multiply stage.
  orient_map_t          map_one;
  orient_map_t          map_two;
  axis3_t               rem_a;
  axis3_t               rem_b;
  logic [2:0][PROD_W-1:0] prod_a_nxt;
  logic [2:0][PROD_W-1:0] prod_b_nxt;
  logic [2:0]           sign_a_nxt;
  logic [2:0]           sign_b_nxt;
  logic                 s1_vld_r;
  logic [2:0][PROD_W-1:0] s1_prod_a_r;
  logic [2:0][PROD_W-1:0] s1_prod_b_r;
  logic [2:0]           s1_sign_a_r;
  logic [2:0]           s1_sign_b_r;
  axis3_t               s1_b_r;

  // Divide stage.
  logic [2:0][SAMPLE_W:0] quot_a_nxt;
  logic [2:0][SAMPLE_W:0] quot_b_nxt;
  logic                 s2_vld_r;
  logic [2:0][SAMPLE_W:0] s2_quot_a_r;
  logic [2:0][SAMPLE_W:0] s2_quot_b_r;
  axis3_t               s2_b_r;

  // Result stage.
  axis3_t               blend;
  axis3_t               main_nxt;
  axis3_t               alt_nxt;
  logic                 out_vld_r;
  axis3_t               main_r;
  axis3_t               alt_r;

  // Scratch for the per-axis arithmetic.
  logic signed [SAMPLE_W-1:0] shf_a;
  logic signed [SAMPLE_W-1:0] shf_b;
  logic signed [SAMPLE_W:0]   diff_a;
  logic signed [SAMPLE_W:0]   diff_b;
  logic [SAMPLE_W:0]          abs_a;
  logic [SAMPLE_W:0]          abs_b;
  logic [PROD_W+RECIP_W-1:0]  rq_a;
  logic [PROD_W+RECIP_W-1:0]  rq_b;
  logic [SAMPLE_W+1:0]        sum;

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      orient_one_r <= '0;
      orient_two_r <= '0;
      ref_mode_r   <= REF_SINGLE;
      zeros_one_r  <= '0;
      zeros_two_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ORIENT_ONE: orient_one_r <= cfg_wdata[ORIENT_W-1:0];
        CFG_ORIENT_TWO: orient_two_r <= cfg_wdata[ORIENT_W-1:0];
        CFG_REF_MODE:   ref_mode_r   <= cfg_wdata[MODE_W-1:0];
        CFG_ZEROS_ONE:  zeros_one_r  <= cfg_wdata[ZEROS_W-1:0];
        CFG_ZEROS_TWO:  zeros_two_r  <= cfg_wdata[ZEROS_W-1:0];
        default: ;
      endcase
    end
  end

  assign pct_sat = (in_blend_percent > FULL_PERCENT) ? FULL_PERCENT : in_blend_percent;

  // Control state of the pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      s0_vld_r  <= 1'b0;
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      busy_r    <= 1'b0;
      s0_vld_r  <= accept;
      s1_vld_r  <= s0_vld_r;
      s2_vld_r  <= s1_vld_r;
      out_vld_r <= s2_vld_r;
    end
  end

  // Payload registers follow the valid bits and need no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      s0_raw_r[AX_R] <= in_sensor_y;
      s0_raw_r[AX_P] <= in_sensor_x;
      s0_raw_r[AX_Y] <= in_sensor_z;
      s0_pct_r       <= pct_sat;
    end
    if (s0_vld_r) begin
      s1_prod_a_r <= prod_a_nxt;
      s1_prod_b_r <= prod_b_nxt;
      s1_sign_a_r <= sign_a_nxt;
      s1_sign_b_r <= sign_b_nxt;
      s1_b_r      <= rem_b;
    end
    if (s1_vld_r) begin
      s2_quot_a_r <= quot_a_nxt;
      s2_quot_b_r <= quot_b_nxt;
      s2_b_r      <= s1_b_r;
    end
    if (s2_vld_r) begin
      main_r <= main_nxt;
      alt_r  <= alt_nxt;
    end
  end

  // Remap each orientation, then scale by its share of the percentage.
  always_comb begin
    // Indexes at or past the orientation count fall back to the first orientation.
    map_one = (orient_one_r < ORIENT_W'(ORIENT_COUNT)) ? orient_lookup(orient_one_r)
                                                       : orient_lookup('0);
    map_two = (orient_two_r < ORIENT_W'(ORIENT_COUNT)) ? orient_lookup(orient_two_r)
                                                       : orient_lookup('0);
    for (int i = 0; i < 3; i++) begin
      shf_a  = $signed(s0_raw_r[map_one.src[i]]) >>> DOWN_SHIFT;
      shf_b  = $signed(s0_raw_r[map_two.src[i]]) >>> DOWN_SHIFT;
      diff_a = (SAMPLE_W+1)'(shf_a) - (SAMPLE_W+1)'($signed(zeros_one_r[i*SAMPLE_W +: SAMPLE_W]));
      diff_b = (SAMPLE_W+1)'(shf_b) - (SAMPLE_W+1)'($signed(zeros_two_r[i*SAMPLE_W +: SAMPLE_W]));
      rem_a[i] = map_one.neg[i] ? SAMPLE_W'(-diff_a) : diff_a[SAMPLE_W-1:0];
      rem_b[i] = map_two.neg[i] ? SAMPLE_W'(-diff_b) : diff_b[SAMPLE_W-1:0];
      // A 16-bit magnitude reaches 32768, so it is kept one bit wider.
      abs_a = rem_a[i][SAMPLE_W-1] ? -(SAMPLE_W+1)'($signed(rem_a[i]))
                                   : {1'b0, rem_a[i]};
      abs_b = rem_b[i][SAMPLE_W-1] ? -(SAMPLE_W+1)'($signed(rem_b[i]))
                                   : {1'b0, rem_b[i]};
      sign_a_nxt[i] = rem_a[i][SAMPLE_W-1];
      sign_b_nxt[i] = rem_b[i][SAMPLE_W-1];
      prod_a_nxt[i] = PROD_W'(abs_a) * PROD_W'(FULL_PERCENT - s0_pct_r);
      prod_b_nxt[i] = PROD_W'(abs_b) * PROD_W'(s0_pct_r);
    end
  end

  // Divide the magnitudes by 100 with a reciprocal multiply, then restore the
  // sign so that each term is truncated toward zero.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rq_a = (PROD_W+RECIP_W)'(s1_prod_a_r[i]) * (PROD_W+RECIP_W)'(RECIP_MULT);
      rq_b = (PROD_W+RECIP_W)'(s1_prod_b_r[i]) * (PROD_W+RECIP_W)'(RECIP_MULT);
      quot_a_nxt[i] = s1_sign_a_r[i]
                    ? (SAMPLE_W+1)'(-$signed({1'b0, rq_a[RECIP_SHIFT +: SAMPLE_W]}))
                    : {1'b0, rq_a[RECIP_SHIFT +: SAMPLE_W]};
      quot_b_nxt[i] = s1_sign_b_r[i]
                    ? (SAMPLE_W+1)'(-$signed({1'b0, rq_b[RECIP_SHIFT +: SAMPLE_W]}))
                    : {1'b0, rq_b[RECIP_SHIFT +: SAMPLE_W]};
    end
  end

  // Sum the two terms, wrap to 16 bits and route by reference mode.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum = (SAMPLE_W+2)'($signed(s2_quot_a_r[i])) + (SAMPLE_W+2)'($signed(s2_quot_b_r[i]));
      blend[i] = sum[SAMPLE_W-1:0];
    end
    case (ref_mode_r)
      REF_SINGLE: begin
        main_nxt = s2_b_r;
        alt_nxt  = s2_b_r;
      end
      REF_MODEL: begin
        main_nxt = s2_b_r;
        alt_nxt  = blend;
      end
      default: begin
        main_nxt = blend;
        alt_nxt  = blend;
      end
    endcase
  end

  assign out_strobe     = out_vld_r;
  assign out_main_roll  = main_r[0];
  assign out_main_pitch = main_r[1];
  assign out_main_yaw   = main_r[2];
  assign out_alt_roll   = alt_r[0];
  assign out_alt_pitch  = alt_r[1];
  assign out_alt_yaw    = alt_r[2];

  `GORB_ASSERT_NEXT(a_accept_enters, accept, s0_vld_r, "accepted item did not enter the pipeline")
  `GORB_ASSERT_ALWAYS(a_fixed_latency, out_strobe == $past(accept, 4), "result strobe does not match accept four cycles earlier")
  `GORB_ASSERT_ALWAYS(a_mode_outputs, !(out_strobe && ref_mode_r != REF_MODEL) || (main_r == alt_r), "main and alternate results differ outside model mode")

endmodule
